@@ design/crwt_pkg.sv @@
// crwt_pkg: shared types, constants and helpers for the recovery window tracker
// depends on nothing; used by every module of the block

package crwt_pkg;

   localparam int unsigned SEQ_W   = 32;
   localparam int unsigned BYTES_W = 24;
   localparam int unsigned CODE_W  = 2;
   localparam int unsigned CSR_INDEX_W = 3;

   localparam logic [BYTES_W-1:0] SEGMENT_BYTES     = 24'd1460;
   localparam logic [BYTES_W-1:0] MIN_WINDOW_RESET  = 24'd5840;
   localparam logic [BYTES_W-1:0] MAX_WINDOW_RESET  = 24'd2920000;
   localparam logic [BYTES_W-1:0] BYTES_MAX         = {BYTES_W{1'b1}};

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_STARTUP_STATE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_WINDOW    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_WINDOW    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RATE_RECOVERY = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RATE_STARTUP  = 3'd4;

   // phase codes as seen on the result word and in the startup register
   localparam logic [CODE_W-1:0] CODE_NONE = 2'd0;
   localparam logic [CODE_W-1:0] CODE_CONS = 2'd1;
   localparam logic [CODE_W-1:0] CODE_MED  = 2'd2;
   localparam logic [CODE_W-1:0] CODE_GROW = 2'd3;

   typedef enum logic [3:0] {
      PH_NONE = 4'b0001,
      PH_CONS = 4'b0010,
      PH_MED  = 4'b0100,
      PH_GROW = 4'b1000
   } phase_type;

   typedef struct packed {
      logic               has_acks;
      logic [SEQ_W-1:0]   last_acked_seq;
      logic [SEQ_W-1:0]   last_sent_seq;
      logic               loss_seen;
      logic               in_startup;
      logic [BYTES_W-1:0] acked_bytes;
      logic [BYTES_W-1:0] lost_bytes;
      logic [BYTES_W-1:0] flight_bytes;
   } req_word_type;

   typedef struct packed {
      logic               round_start;
      logic [CODE_W-1:0]  recovery_phase;
      logic [BYTES_W-1:0] recovery_bytes;
      logic               window_clamped;
   } rsp_word_type;

   typedef struct packed {
      logic [CODE_W-1:0]  startup_recovery_state;
      logic [BYTES_W-1:0] min_window;
      logic [BYTES_W-1:0] max_window;
      logic               freeze_window;
      logic               freeze_in_startup;
   } cfg_type;

   typedef struct packed {
      logic [SEQ_W-1:0]   round_end_seq;
      logic [SEQ_W-1:0]   round_total;
      phase_type          phase;
      logic [SEQ_W-1:0]   recovery_end_seq;
      logic               recovery_end_valid;
      logic [BYTES_W-1:0] window_bytes;
   } state_type;

   function automatic logic [CODE_W-1:0] phase_code(input phase_type ph);
      logic [CODE_W-1:0] code;
      case (ph)
         PH_NONE: code = CODE_NONE;
         PH_CONS: code = CODE_CONS;
         PH_MED:  code = CODE_MED;
         PH_GROW: code = CODE_GROW;
         default: code = CODE_NONE;
      endcase
      return code;
   endfunction

   // zero in the startup register means conservation
   function automatic phase_type startup_phase(input logic [CODE_W-1:0] code);
      phase_type ph;
      case (code)
         CODE_CONS: ph = PH_CONS;
         CODE_MED:  ph = PH_MED;
         CODE_GROW: ph = PH_GROW;
         default:   ph = PH_CONS;
      endcase
      return ph;
   endfunction

   function automatic logic [BYTES_W-1:0] sat_add(input logic [BYTES_W-1:0] a,
                                                  input logic [BYTES_W-1:0] b);
      logic [BYTES_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[BYTES_W] ? BYTES_MAX : s[BYTES_W-1:0];
   endfunction

   function automatic logic [BYTES_W-1:0] max_bytes(input logic [BYTES_W-1:0] a,
                                                    input logic [BYTES_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

endpackage

@@ design/congestion_recovery_window_tracker_core.sv @@
// congestion_recovery_window_tracker_core: top level of the recovery window tracker
// depends on crwt_pkg, crwt_csr and crwt_update

// One feedback report in, one result word out. A report is captured in an input
// register, evaluated against the tracker state in a single pass and written with
// the new state into the result register, so a report can be taken every clock
// while req_ready is high; rsp_valid rises as the result register is loaded. The
// result register decouples the sides: the next report is taken while a result
// waits, and only a full pipeline with rsp_ready low holds req_ready low.
// Configuration writes are always accepted and take effect on the next report.

module congestion_recovery_window_tracker_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  crwt_pkg::req_word_type            req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output crwt_pkg::rsp_word_type            rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [crwt_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [crwt_pkg::BYTES_W-1:0]      csr_data
);

   crwt_pkg::cfg_type       cfg;
   crwt_pkg::req_word_type  in_ff;
   logic                    in_valid_ff;
   crwt_pkg::state_type     state_ff;
   crwt_pkg::state_type     state_in;
   crwt_pkg::rsp_word_type  rsp_ff;
   crwt_pkg::rsp_word_type  rsp_in;
   logic                    rsp_valid_ff;
   logic                    advance;

   crwt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   crwt_update u_update (
      .cfg        (cfg),
      .state_cur  (state_ff),
      .req        (in_ff),
      .state_next (state_in),
      .rsp        (rsp_in)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         in_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.round_end_seq      <= '0;
         state_ff.round_total        <= '0;
         state_ff.phase              <= crwt_pkg::PH_NONE;
         state_ff.recovery_end_seq   <= '0;
         state_ff.recovery_end_valid <= 1'b0;
         state_ff.window_bytes       <= crwt_pkg::MAX_WINDOW_RESET;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   a_no_clamp_outside_recovery: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.recovery_phase == crwt_pkg::CODE_NONE) |-> !rsp_ff.window_clamped)
      else $error("window clamped while not in recovery");

   a_round_needs_acks: assert property (@(posedge clock) disable iff (reset)
      (advance && !in_ff.has_acks) |=> !rsp_ff.round_start)
      else $error("round start on a word without acks");

   a_recovery_end_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(state_ff.recovery_end_valid))
      else $error("recovery end mark cleared outside reset");

   a_state_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("tracker state changed without a word advancing");

endmodule

@@ design/crwt_csr.sv @@
// crwt_csr: configuration registers of the recovery window tracker
// depends on crwt_pkg

module crwt_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [crwt_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [crwt_pkg::BYTES_W-1:0]       csr_data,
   output crwt_pkg::cfg_type                  cfg
);

   crwt_pkg::cfg_type cfg_ff;
   crwt_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            crwt_pkg::CSR_STARTUP_STATE:
               cfg_in.startup_recovery_state = csr_data[crwt_pkg::CODE_W-1:0];
            crwt_pkg::CSR_MIN_WINDOW:    cfg_in.min_window = csr_data;
            crwt_pkg::CSR_MAX_WINDOW:    cfg_in.max_window = csr_data;
            crwt_pkg::CSR_RATE_RECOVERY: cfg_in.freeze_window = csr_data[0];
            crwt_pkg::CSR_RATE_STARTUP:  cfg_in.freeze_in_startup = csr_data[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.startup_recovery_state <= crwt_pkg::CODE_CONS;
         cfg_ff.min_window             <= crwt_pkg::MIN_WINDOW_RESET;
         cfg_ff.max_window             <= crwt_pkg::MAX_WINDOW_RESET;
         cfg_ff.freeze_window          <= 1'b0;
         cfg_ff.freeze_in_startup      <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ design/crwt_update.sv @@
// crwt_update: round tracking, recovery phase and window update for one word
// depends on crwt_pkg; purely combinational

module crwt_update (
   input  crwt_pkg::cfg_type      cfg,
   input  crwt_pkg::state_type    state_cur,
   input  crwt_pkg::req_word_type req,
   output crwt_pkg::state_type    state_next,
   output crwt_pkg::rsp_word_type rsp
);

   logic                          rstart;
   logic                          frozen;
   logic [crwt_pkg::BYTES_W-1:0]  need;
   logic [crwt_pkg::BYTES_W-1:0]  w;

   always_comb begin
      state_next = state_cur;
      rstart = 1'b0;
      frozen = cfg.freeze_window || (cfg.freeze_in_startup && req.in_startup);
      need = crwt_pkg::sat_add(req.flight_bytes, req.acked_bytes);
      w = '0;

      if (req.has_acks) begin
         if (req.last_acked_seq > state_cur.round_end_seq) begin
            state_next.round_total   = state_cur.round_total + 32'd1;
            state_next.round_end_seq = req.last_sent_seq;
            rstart = 1'b1;
         end
         if (req.loss_seen) begin
            state_next.recovery_end_seq   = req.last_acked_seq;
            state_next.recovery_end_valid = 1'b1;
         end
         if (state_cur.phase == crwt_pkg::PH_NONE) begin
            if (req.loss_seen) begin
               state_next.phase = req.in_startup ?
                  crwt_pkg::startup_phase(cfg.startup_recovery_state) : crwt_pkg::PH_CONS;
               state_next.window_bytes  = '0;
               state_next.round_end_seq = req.last_acked_seq;
            end
         end else begin
            if (state_cur.phase != crwt_pkg::PH_GROW && rstart) begin
               state_next.phase = crwt_pkg::PH_GROW;
            end
            if (!req.loss_seen && (!state_cur.recovery_end_valid ||
                                   state_cur.recovery_end_seq < req.last_acked_seq)) begin
               state_next.phase = crwt_pkg::PH_NONE;
            end
         end
      end

      if (!frozen && state_next.phase != crwt_pkg::PH_NONE) begin
         if (state_next.window_bytes == '0) begin
            state_next.window_bytes = crwt_pkg::max_bytes(cfg.min_window, need);
         end else begin
            w = (state_next.window_bytes >= req.lost_bytes) ?
                state_next.window_bytes - req.lost_bytes : crwt_pkg::SEGMENT_BYTES;
            if (state_next.phase == crwt_pkg::PH_GROW) begin
               w = crwt_pkg::sat_add(w, req.acked_bytes);
            end else if (state_next.phase == crwt_pkg::PH_MED) begin
               w = crwt_pkg::sat_add(w, req.acked_bytes >> 1);
            end
            w = crwt_pkg::max_bytes(w, need);
            state_next.window_bytes = crwt_pkg::max_bytes(cfg.min_window, w);
         end
      end

      rsp.round_start    = rstart;
      rsp.recovery_phase = crwt_pkg::phase_code(state_next.phase);
      rsp.recovery_bytes = state_next.window_bytes;
      rsp.window_clamped = (state_next.phase != crwt_pkg::PH_NONE) && !frozen;
   end

endmodule

@@ sim/tb_congestion_recovery_window_tracker_core.sv @@
// tb_congestion_recovery_window_tracker_core: self-checking bench for the recovery window tracker
// directed reports, then random report streams under a sweep of register settings
// depends on crwt_pkg and congestion_recovery_window_tracker_core

module tb_congestion_recovery_window_tracker_core;

   localparam int QUIET_LIMIT   = 3000;
   localparam int SETTLE_CYCLES = 8;
   localparam logic [crwt_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 3'd7;

   typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_CYCLIC} ready_mode_type;
   typedef logic [crwt_pkg::BYTES_W-1:0] bytes_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   crwt_pkg::req_word_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   crwt_pkg::rsp_word_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [crwt_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [crwt_pkg::BYTES_W-1:0] csr_data = '0;

   // tracker copy kept in step with the block
   crwt_pkg::cfg_type shadow_cfg = '{crwt_pkg::CODE_CONS, crwt_pkg::MIN_WINDOW_RESET,
                                     crwt_pkg::MAX_WINDOW_RESET, 1'b0, 1'b0};
   logic [crwt_pkg::SEQ_W-1:0] round_end = '0;
   logic [crwt_pkg::SEQ_W-1:0] round_count = '0;
   logic [crwt_pkg::CODE_W-1:0] cur_phase = crwt_pkg::CODE_NONE;
   logic [crwt_pkg::SEQ_W-1:0] recov_end = '0;
   logic recov_set = 1'b0;
   logic [crwt_pkg::BYTES_W-1:0] window = crwt_pkg::MAX_WINDOW_RESET;

   crwt_pkg::rsp_word_type pending_results[$];
   int reports_sent = 0;
   int results_seen = 0;
   int mismatches = 0;
   int burst_left = 0;
   int quiet_cycles = 0;
   logic [crwt_pkg::SEQ_W-1:0] flow_ack = '0;

   ready_mode_type ready_mode = READY_ALWAYS;
   int mode_left = 0;
   int cycle_count = 0;

   congestion_recovery_window_tracker_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic bytes_type add_clip(input bytes_type a, input bytes_type b);
      logic [crwt_pkg::BYTES_W:0] total;
      total = {1'b0, a} + {1'b0, b};
      return total[crwt_pkg::BYTES_W] ? crwt_pkg::BYTES_MAX : total[crwt_pkg::BYTES_W-1:0];
   endfunction

   function automatic crwt_pkg::rsp_word_type step_tracker(input crwt_pkg::req_word_type r);
      crwt_pkg::rsp_word_type e;
      logic started;
      logic frozen;
      bytes_type need;
      bytes_type w;
      started = 1'b0;
      frozen = shadow_cfg.freeze_window || (shadow_cfg.freeze_in_startup && r.in_startup);
      if (r.has_acks) begin
         if (r.last_acked_seq > round_end) begin
            round_count = round_count + 1;
            round_end = r.last_sent_seq;
            started = 1'b1;
         end
         if (r.loss_seen) begin
            recov_end = r.last_acked_seq;
            recov_set = 1'b1;
         end
         if (cur_phase == crwt_pkg::CODE_NONE) begin
            if (r.loss_seen) begin
               if (r.in_startup && shadow_cfg.startup_recovery_state != crwt_pkg::CODE_NONE)
                  cur_phase = shadow_cfg.startup_recovery_state;
               else
                  cur_phase = crwt_pkg::CODE_CONS;
               window = '0;
               round_end = r.last_acked_seq;
            end
         end else begin
            if (cur_phase != crwt_pkg::CODE_GROW && started)
               cur_phase = crwt_pkg::CODE_GROW;
            if (!r.loss_seen && (!recov_set || recov_end < r.last_acked_seq))
               cur_phase = crwt_pkg::CODE_NONE;
         end
      end
      if (!frozen && cur_phase != crwt_pkg::CODE_NONE) begin
         need = add_clip(r.flight_bytes, r.acked_bytes);
         if (window == '0) begin
            window = (shadow_cfg.min_window > need) ? shadow_cfg.min_window : need;
         end else begin
            w = (window >= r.lost_bytes) ? window - r.lost_bytes : crwt_pkg::SEGMENT_BYTES;
            if (cur_phase == crwt_pkg::CODE_GROW)
               w = add_clip(w, r.acked_bytes);
            else if (cur_phase == crwt_pkg::CODE_MED)
               w = add_clip(w, r.acked_bytes >> 1);
            if (need > w)
               w = need;
            if (shadow_cfg.min_window > w)
               w = shadow_cfg.min_window;
            window = w;
         end
      end
      e.round_start    = started;
      e.recovery_phase = cur_phase;
      e.recovery_bytes = window;
      e.window_clamped = (cur_phase != crwt_pkg::CODE_NONE) && !frozen;
      return e;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : track_words
      crwt_pkg::rsp_word_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               crwt_pkg::CSR_STARTUP_STATE:
                  shadow_cfg.startup_recovery_state = csr_data[crwt_pkg::CODE_W-1:0];
               crwt_pkg::CSR_MIN_WINDOW:    shadow_cfg.min_window = csr_data;
               crwt_pkg::CSR_MAX_WINDOW:    shadow_cfg.max_window = csr_data;
               crwt_pkg::CSR_RATE_RECOVERY: shadow_cfg.freeze_window = csr_data[0];
               crwt_pkg::CSR_RATE_STARTUP:  shadow_cfg.freeze_in_startup = csr_data[0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
               $error("result word with nothing expected");
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               compare_field("round_start", 32'(want.round_start),
                             32'(rsp_data.round_start));
               compare_field("recovery_phase", 32'(want.recovery_phase),
                             32'(rsp_data.recovery_phase));
               compare_field("recovery_bytes", 32'(want.recovery_bytes),
                             32'(rsp_data.recovery_bytes));
               compare_field("window_clamped", 32'(want.window_clamped),
                             32'(rsp_data.window_clamped));
            end
         end
         if (req_valid && req_ready)
            pending_results.push_back(step_tracker(req_data));
      end
   end

   always @(posedge clock) begin
      if (mode_left == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         mode_left = $urandom_range(20, 200);
      end else begin
         mode_left--;
      end
      cycle_count++;
      case (ready_mode)
         READY_ALWAYS: rsp_ready <= 1'b1;
         READY_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
         READY_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
         default:      rsp_ready <= (cycle_count % 3 != 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic crwt_pkg::req_word_type make_report(input logic ack_flag,
                                                input logic [crwt_pkg::SEQ_W-1:0] ack_seq,
                                                input logic [crwt_pkg::SEQ_W-1:0] sent_seq,
                                                input logic loss, input logic startup,
                                                input bytes_type acked,
                                                input bytes_type lost,
                                                input bytes_type flight);
      crwt_pkg::req_word_type r;
      r.has_acks       = ack_flag;
      r.last_acked_seq = ack_seq;
      r.last_sent_seq  = sent_seq;
      r.loss_seen      = loss;
      r.in_startup     = startup;
      r.acked_bytes    = acked;
      r.lost_bytes     = lost;
      r.flight_bytes   = flight;
      return r;
   endfunction

   function automatic bytes_type draw_bytes(input int unsigned span);
      case ($urandom_range(0, 19))
         0:       return '0;
         1:       return crwt_pkg::BYTES_MAX;
         2, 3:    return bytes_type'($urandom_range(0, crwt_pkg::BYTES_MAX));
         default: return bytes_type'($urandom_range(0, span));
      endcase
   endfunction

   task automatic send_report(input crwt_pkg::req_word_type r);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 30);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
      reports_sent++;
   endtask

   task automatic settle_block();
      req_valid <= 1'b0;
      burst_left = 0;
      while (results_seen != reports_sent) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [crwt_pkg::CSR_INDEX_W-1:0] index,
                                 input bytes_type value);
      settle_block();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_traffic(input int count, input int loss_pct, input int startup_pct,
                              input int noise_pct);
      crwt_pkg::req_word_type r;
      int unsigned pick;
      flow_ack = $urandom_range(1000, 1 << 20);
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         r.loss_seen    = ($urandom_range(0, 99) < loss_pct);
         r.in_startup   = ($urandom_range(0, 99) < startup_pct);
         r.acked_bytes  = draw_bytes(4000);
         r.flight_bytes = draw_bytes(30000);
         if (r.loss_seen)
            r.lost_bytes = draw_bytes(8000);
         else
            r.lost_bytes = ($urandom_range(0, 9) == 0) ? draw_bytes(2000) : '0;
         if (pick < noise_pct) begin
            r.has_acks       = 1'($urandom_range(0, 1));
            r.last_acked_seq = $urandom();
            r.last_sent_seq  = $urandom();
            r.loss_seen      = 1'($urandom_range(0, 1));
            r.in_startup     = 1'($urandom_range(0, 1));
            r.acked_bytes    = bytes_type'($urandom_range(0, crwt_pkg::BYTES_MAX));
            r.lost_bytes     = bytes_type'($urandom_range(0, crwt_pkg::BYTES_MAX));
            r.flight_bytes   = bytes_type'($urandom_range(0, crwt_pkg::BYTES_MAX));
         end else if (pick < noise_pct + 8) begin
            // out-of-order acks and jumps in the sent sequence
            r.has_acks       = 1'($urandom_range(0, 1));
            r.last_acked_seq = flow_ack - $urandom_range(1, 60);
            r.last_sent_seq  = flow_ack + $urandom_range(0, 2000);
         end else begin
            if ($urandom_range(0, 9) >= 4)
               flow_ack = flow_ack + $urandom_range(1, 3);
            r.has_acks       = ($urandom_range(0, 9) != 0);
            r.last_acked_seq = flow_ack;
            r.last_sent_seq  = flow_ack + $urandom_range(0, 40);
         end
         send_report(r);
      end
   endtask

   task automatic test_idle_reports();
      send_report(make_report(1'b0, '1, '1, 1'b1, 1'b1, crwt_pkg::BYTES_MAX,
                              crwt_pkg::BYTES_MAX, crwt_pkg::BYTES_MAX));
      send_report(make_report(1'b1, '0, '0, 1'b0, 1'b0, '0, '0, '0));
   endtask

   task automatic test_recovery_entry();
      send_report(make_report(1'b1, 10, 100, 1'b0, 1'b0, 0, 0, 0));
      send_report(make_report(1'b1, 20, 120, 1'b1, 1'b0, 1000, 0, 3000));
      send_report(make_report(1'b1, 20, 130, 1'b0, 1'b0, 500, 100000, 2000));
      send_report(make_report(1'b1, 21, 140, 1'b1, 1'b0, 2000, 300, 1000));
      send_report(make_report(1'b1, 22, 150, 1'b0, 1'b0, 100, 0, 100));
      send_report(make_report(1'b1, 30, 160, 1'b1, 1'b0, crwt_pkg::BYTES_MAX,
                              crwt_pkg::BYTES_MAX, crwt_pkg::BYTES_MAX));
      send_report(make_report(1'b1, 30, 160, 1'b1, 1'b0, crwt_pkg::BYTES_MAX, 0,
                              crwt_pkg::BYTES_MAX));
      send_report(make_report(1'b0, 31, 170, 1'b0, 1'b0, 10, 10, 10));
      send_report(make_report(1'b1, 31, 170, 1'b0, 1'b0, 0, 0, 0));
   endtask

   task automatic test_startup_phases();
      write_register(crwt_pkg::CSR_STARTUP_STATE, bytes_type'(crwt_pkg::CODE_MED));
      send_report(make_report(1'b1, 40, 200, 1'b1, 1'b1, 3001, 0, 1000));
      send_report(make_report(1'b1, 40, 200, 1'b0, 1'b1, 3001, 0, 1000));
      send_report(make_report(1'b1, 41, 210, 1'b0, 1'b1, 0, 0, 0));
      write_register(crwt_pkg::CSR_STARTUP_STATE, bytes_type'(crwt_pkg::CODE_NONE));
      send_report(make_report(1'b1, 50, 220, 1'b1, 1'b1, 700, 0, 700));
      send_report(make_report(1'b1, 51, 230, 1'b0, 1'b1, 0, 0, 0));
      write_register(crwt_pkg::CSR_STARTUP_STATE, bytes_type'(crwt_pkg::CODE_GROW));
      send_report(make_report(1'b1, 60, 240, 1'b1, 1'b1, 900, 0, 9000));
      send_report(make_report(1'b1, 61, 250, 1'b0, 1'b0, 0, 0, 0));
      send_report(make_report(1'b1, 70, 260, 1'b1, 1'b0, 900, 0, 9000));
      send_report(make_report(1'b1, 71, 270, 1'b0, 1'b0, 0, 0, 0));
      write_register(crwt_pkg::CSR_STARTUP_STATE, bytes_type'(crwt_pkg::CODE_CONS));
   endtask

   task automatic test_rate_based_freeze();
      write_register(crwt_pkg::CSR_RATE_RECOVERY, 1);
      send_report(make_report(1'b1, 80, 300, 1'b1, 1'b0, 1000, 0, 8000));
      write_register(crwt_pkg::CSR_RATE_RECOVERY, 0);
      send_report(make_report(1'b1, 80, 300, 1'b1, 1'b0, 1000, 0, 8000));
      write_register(crwt_pkg::CSR_RATE_STARTUP, 1);
      send_report(make_report(1'b1, 80, 300, 1'b1, 1'b1, 1000, 200, 8000));
      send_report(make_report(1'b1, 80, 300, 1'b1, 1'b0, 1000, 200, 8000));
      send_report(make_report(1'b1, 81, 310, 1'b0, 1'b0, 0, 0, 0));
      write_register(crwt_pkg::CSR_RATE_STARTUP, 0);
   endtask

   task automatic test_sequence_extremes();
      write_register(crwt_pkg::CSR_MAX_WINDOW, crwt_pkg::BYTES_MAX);
      send_report(make_report(1'b1, '1, '1, 1'b0, 1'b0, 0, 0, 0));
      send_report(make_report(1'b1, '1, '0, 1'b1, 1'b0, 100, 0, 100));
      send_report(make_report(1'b1, '0, '0, 1'b0, 1'b0, 0, 0, 0));
      send_report(make_report(1'b1, 5, 9, 1'b1, 1'b0, 0, 0, 0));
      send_report(make_report(1'b1, 6, 10, 1'b0, 1'b0, 0, 0, 0));
      write_register(crwt_pkg::CSR_MAX_WINDOW, crwt_pkg::MAX_WINDOW_RESET);
   endtask

   task automatic test_config_sweep();
      write_register(CSR_UNUSED_INDEX, crwt_pkg::BYTES_MAX);
      run_traffic(230, 15, 30, 7);
      write_register(crwt_pkg::CSR_STARTUP_STATE, bytes_type'(crwt_pkg::CODE_MED));
      run_traffic(230, 15, 70, 7);
      write_register(crwt_pkg::CSR_STARTUP_STATE, bytes_type'(crwt_pkg::CODE_GROW));
      write_register(crwt_pkg::CSR_MIN_WINDOW, '0);
      write_register(crwt_pkg::CSR_MAX_WINDOW, '0);
      run_traffic(230, 20, 50, 7);
      write_register(crwt_pkg::CSR_STARTUP_STATE, bytes_type'(crwt_pkg::CODE_NONE));
      write_register(crwt_pkg::CSR_MIN_WINDOW, crwt_pkg::BYTES_MAX);
      write_register(crwt_pkg::CSR_MAX_WINDOW, crwt_pkg::BYTES_MAX);
      run_traffic(230, 15, 50, 7);
      write_register(crwt_pkg::CSR_MIN_WINDOW, 3000);
      write_register(crwt_pkg::CSR_RATE_RECOVERY, 1);
      run_traffic(230, 15, 30, 7);
      write_register(crwt_pkg::CSR_RATE_RECOVERY, 0);
      write_register(crwt_pkg::CSR_RATE_STARTUP, 1);
      run_traffic(230, 20, 50, 7);
      write_register(crwt_pkg::CSR_RATE_STARTUP, 0);
      write_register(crwt_pkg::CSR_STARTUP_STATE, bytes_type'(crwt_pkg::CODE_CONS));
      write_register(crwt_pkg::CSR_MIN_WINDOW, bytes_type'($urandom_range(0, 20000)));
      run_traffic(230, 30, 30, 7);
      write_register(crwt_pkg::CSR_MIN_WINDOW, crwt_pkg::MIN_WINDOW_RESET);
      write_register(crwt_pkg::CSR_MAX_WINDOW, crwt_pkg::MAX_WINDOW_RESET);
      run_traffic(230, 5, 20, 7);
   endtask

   task automatic test_noise_reports();
      run_traffic(100, 15, 50, 100);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_idle_reports();
      test_recovery_entry();
      test_startup_phases();
      test_rate_based_freeze();
      test_sequence_extremes();
      test_config_sweep();
      test_noise_reports();
      settle_block();
      if (pending_results.size() != 0) begin
         $error("result words still expected: %0d", pending_results.size());
         mismatches++;
      end
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

@@ sim.f @@
design/crwt_pkg.sv
design/crwt_csr.sv
design/crwt_update.sv
design/congestion_recovery_window_tracker_core.sv
sim/tb_congestion_recovery_window_tracker_core.sv
